FILE: design/lru_key_value_cache_assert.svh
// Assertion macros used by the cache datapath.
// Included by the datapath, the module that carries concurrent checks; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LKVC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

FILE: design/lkvc_pkg.sv
// Shared constants and command types for the LRU key-value cache.
// No dependencies; imported by every cache module.
`default_nettype none

package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam int S_DATA_W = KEY_W + VAL_W;
  localparam int M_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NOTFOUND = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic lookup;   // compare keys, register hit and replacement info
    logic commit;   // update stores, load the output register
  } lkvc_cmd_t;

endpackage

`default_nettype wire

FILE: design/lru_key_value_cache.sv
// Fully associative 16-entry key-value cache with least-recently-used replacement.
// The result beat is registered: the request is captured, the lookup registers the parallel key compare,
// and the commit updates the stores and ranks and loads the output register, stalling while a result is held.
// A new request is accepted while the previous one commits; none is taken during its lookup.
// Reset (rst, synchronous): all entries invalid, count zero, capacity 16.
`default_nettype none

module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // key[31:0], value_in[63:32]
  input  wire logic                s_tuser,   // kind
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,   // value_out[31:0], entry_count[36:32], zero pad
  output logic                     m_tuser,   // status
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CAP_W-1:0]    cfg_data   // capacity
);

  lkvc_cmd_t        cmd;
  logic [VAL_W-1:0] out_value;
  logic [CNT_W-1:0] out_count;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lkvc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_kind_in  (s_tuser),
    .req_key_in   (s_tdata[KEY_W-1:0]),
    .req_value_in (s_tdata[KEY_W +: VAL_W]),
    .cap_we       (cfg_valid && cfg_ready),
    .cap_data     (cfg_data),
    .out_status   (m_tuser),
    .out_value    (out_value),
    .out_count    (out_count)
  );

  assign m_tdata = M_DATA_W'({out_count, out_value});

endmodule

`default_nettype wire

FILE: design/lkvc_datapath.sv
// Datapath: key/value/rank stores, parallel key compare, LRU update, result register.
// Depends on lkvc_pkg and the assertion macro header.
`default_nettype none
`include "lru_key_value_cache_assert.svh"

module lkvc_datapath
  import lkvc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lkvc_cmd_t        cmd,
  input  wire logic             req_kind_in,
  input  wire logic [KEY_W-1:0] req_key_in,
  input  wire logic [VAL_W-1:0] req_value_in,
  input  wire logic             cap_we,
  input  wire logic [CAP_W-1:0] cap_data,
  output logic                  out_status,
  output logic [VAL_W-1:0]      out_value,
  output logic [CNT_W-1:0]      out_count
);

  // request registers
  logic             req_kind;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;

  // stores
  logic [KEY_W-1:0] key_store   [MAX_ENTRIES];
  logic [VAL_W-1:0] value_store [MAX_ENTRIES];
  logic [IDX_W-1:0] rank        [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0] held_count;
  logic [CAP_W-1:0] capacity;

  // lookup-stage registers
  logic                   hit;
  logic [MAX_ENTRIES-1:0] hit_oh;
  logic [IDX_W-1:0]       hit_rank;
  logic [VAL_W-1:0]       hit_value;
  logic                   do_evict;
  logic [MAX_ENTRIES-1:0] keep_mask;
  logic [MAX_ENTRIES-1:0] ins_oh;

  // lookup combinational
  logic [MAX_ENTRIES-1:0] match_c;
  logic [MAX_ENTRIES-1:0] victim_c;
  logic [MAX_ENTRIES-1:0] keep_c;
  logic [IDX_W-1:0]       hit_idx_c;
  logic [CAP_W-1:0]       eff_cap_c;
  logic [CNT_W-1:0]       oldest_c;
  logic                   evict_c;

  always_comb begin
    if (capacity == '0) begin
      eff_cap_c = CAP_W'(1);
    end else if (capacity > CAP_W'(MAX_ENTRIES)) begin
      eff_cap_c = CAP_W'(MAX_ENTRIES);
    end else begin
      eff_cap_c = capacity;
    end
  end

  assign evict_c  = (held_count >= CNT_W'(eff_cap_c));
  assign oldest_c = held_count - CNT_W'(1);

  always_comb begin
    hit_idx_c = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_c[i]  = entry_valid[i] && (key_store[i] == req_key);
      victim_c[i] = entry_valid[i] && (CNT_W'(rank[i]) == oldest_c);
      if (match_c[i]) begin
        hit_idx_c = hit_idx_c | IDX_W'(i);
      end
    end
  end

  assign keep_c = entry_valid & ~(evict_c ? victim_c : '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= req_kind_in;
      req_key   <= req_key_in;
      req_value <= req_value_in;
    end
    if (cmd.lookup) begin
      hit       <= |match_c;
      hit_oh    <= match_c;
      hit_rank  <= rank[hit_idx_c];
      hit_value <= value_store[hit_idx_c];
      do_evict  <= evict_c;
      keep_mask <= keep_c;
      // lowest free slot once the victim is dropped
      ins_oh    <= ~keep_c & (keep_c + MAX_ENTRIES'(1));
    end
  end

  // commit: stores, ranks and output payload
  logic ins_c;
  assign ins_c = (req_kind == KIND_PUT) && !hit;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (hit) begin
          if (hit_oh[i]) begin
            rank[i] <= '0;
            if (req_kind == KIND_PUT) begin
              value_store[i] <= req_value;
            end
          end else if (entry_valid[i] && rank[i] < hit_rank) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end else if (ins_c) begin
          if (ins_oh[i]) begin
            rank[i]        <= '0;
            key_store[i]   <= req_key;
            value_store[i] <= req_value;
          end else if (keep_mask[i]) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
      end
      out_status <= (req_kind == KIND_GET && !hit) ? STATUS_NOTFOUND : STATUS_OK;
      out_value  <= (req_kind == KIND_GET && hit) ? hit_value : '0;
      out_count  <= (ins_c && !do_evict) ? held_count + CNT_W'(1) : held_count;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      held_count  <= '0;
      capacity    <= CAP_RESET;
    end else begin
      if (cap_we) begin
        capacity <= cap_data;
      end
      if (cmd.commit && ins_c) begin
        entry_valid <= keep_mask | ins_oh;
        if (!do_evict) begin
          held_count <= held_count + CNT_W'(1);
        end
      end
    end
  end

  `LKVC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, held_count <= CNT_W'(MAX_ENTRIES))
  `LKVC_ASSERT_NOW(a_count_tracks_valid, clk, rst, 1'b1,
                   $countones(entry_valid) == int'(held_count))
  `LKVC_ASSERT_NOW(a_unique_key, clk, rst, cmd.lookup, $onehot0(match_c))
  `LKVC_ASSERT_NOW(a_insert_slot, clk, rst, cmd.commit && ins_c, $onehot(ins_oh))

endmodule

`default_nettype wire

FILE: design/lkvc_ctrl.sv
// Controller: request sequencing and the output beat handshake.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  output lkvc_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  // result register can take a new beat this cycle
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_COMMIT: s_tready = out_free;
      default:   s_tready = 1'b0;
    endcase
  end

  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.lookup  = (state == ST_LOOKUP);
  assign cmd.commit  = (state == ST_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) begin
            state <= cmd.capture ? ST_LOOKUP : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/lru_key_value_cache_tb.sv
// Self-checking testbench for lru_key_value_cache: a shadow LRU cache predicts each result.
// Needs lkvc_pkg and the cache RTL only; directed requests first, then random phases
// at several capacity settings, with random idling on both streams.
`timescale 1ns / 1ps

module lru_key_value_cache_tb
  import lkvc_pkg::*;
();

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 150;
  localparam int REPORT_LINES = 100;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } cache_reply_t;

  // Shadow copy of the cache; one expected reply per accepted request.
  class cache_shadow;
    logic [KEY_W-1:0] keys [MAX_ENTRIES];
    logic [VAL_W-1:0] vals [MAX_ENTRIES];
    bit               live [MAX_ENTRIES];
    int unsigned      age  [MAX_ENTRIES];  // 0 is the most recent
    int unsigned      held;
    logic [CAP_W-1:0] cap_reg;
    cache_reply_t     due_replies [$];
    int unsigned      mismatches;

    function new();
      cap_reg    = CAP_RESET;
      held       = 0;
      mismatches = 0;
      foreach (live[i]) begin
        live[i] = 1'b0;
        age[i]  = 0;
      end
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap_reg = c;
    endfunction

    function int unsigned room();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > MAX_ENTRIES) c = MAX_ENTRIES;
      return c;
    endfunction

    function int locate(logic [KEY_W-1:0] k);
      foreach (live[i])
        if (live[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function void refresh(int s);
      int unsigned r;
      r = age[s];
      foreach (live[i])
        if (live[i] && age[i] < r) age[i]++;
      age[s] = 0;
    endfunction

    function void drop_oldest();
      int victim;
      victim = -1;
      foreach (live[i])
        if (live[i] && (victim < 0 || age[i] >= age[victim])) victim = i;
      if (victim >= 0) begin
        live[victim] = 1'b0;
        if (held > 0) held--;
      end
    endfunction

    function void store_new(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int slot;
      slot = -1;
      foreach (live[i])
        if (!live[i] && slot < 0) slot = i;
      if (slot < 0) return;
      foreach (live[i])
        if (live[i]) age[i]++;
      keys[slot] = k;
      vals[slot] = v;
      age[slot]  = 0;
      live[slot] = 1'b1;
      held++;
    endfunction

    function void take_request(logic kind, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      cache_reply_t r;
      int s;
      s        = locate(k);
      r.status = STATUS_OK;
      r.value  = '0;
      if (kind == KIND_GET) begin
        if (s >= 0) begin
          r.value = vals[s];
          refresh(s);
        end else begin
          r.status = STATUS_NOTFOUND;
        end
      end else if (s >= 0) begin
        vals[s] = v;
        refresh(s);
      end else begin
        // a lowered capacity still evicts only one entry per new key
        if (held >= room()) drop_oldest();
        store_new(k, v);
      end
      r.count = CNT_W'(held);
      due_replies.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < REPORT_LINES) $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task match_reply(logic status, logic [VAL_W-1:0] value, logic [CNT_W-1:0] count);
      cache_reply_t want;
      if (due_replies.size() == 0) begin
        report($sformatf("result beat with none due: status=%0b value=%h count=%0d",
                         status, value, count));
        return;
      end
      want = due_replies.pop_front();
      if (status !== want.status)
        report($sformatf("status %0b, want %0b", status, want.status));
      if (value !== want.value)
        report($sformatf("value_out %h, want %h", value, want.value));
      if (count !== want.count)
        report($sformatf("entry_count %0d, want %0d", count, want.count));
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;  // key[31:0], value_in[63:32]
  logic                s_tuser   = 1'b0;  // kind
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;  // value_out[31:0], entry_count[36:32], zero pad
  logic                m_tuser;  // status
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_data  = '0;

  cache_shadow shadow = new();
  bit quiet        = 1'b0;  // no idling on either side
  bit hold_off_req = 1'b0;

  lru_key_value_cache uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Monitors sample before this edge's updates land
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      shadow.take_request(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W +: VAL_W]);
    if (!rst && cfg_valid && cfg_ready)
      shadow.set_capacity(cfg_data);
    if (!rst && m_tvalid && m_tready)
      shadow.match_reply(m_tuser, m_tdata[VAL_W-1:0], m_tdata[VAL_W +: CNT_W]);
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        stall        = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = gap_len();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_request(logic kind, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v, k};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
  endtask

  // Only with the stream drained and the pipeline left to settle
  task automatic write_capacity(logic [CAP_W-1:0] c);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.due_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [8];
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] k;
    logic             kind;
    int               pool_n;
    phase_caps = '{5'd6, 5'd31, 5'd1, 5'd4, 5'd16, 5'd0, 5'd9, 5'd2};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty miss, extreme keys and values, hit, overwrite
    send_request(KIND_GET, 32'h0000_0000, $urandom());
    send_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_GET, 32'h8000_0000, $urandom());
    send_request(KIND_GET, 32'h1234_5678, $urandom());
    send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
    send_request(KIND_GET, 32'h7FFF_FFFF, $urandom());
    // capacity below the count: one eviction per new key, count holds
    write_capacity(5'd3);
    send_request(KIND_PUT, 32'h0000_0005, $urandom());
    send_request(KIND_GET, 32'h0000_0000, $urandom());
    send_request(KIND_GET, 32'h0000_0005, $urandom());
    // zero capacity behaves as one
    write_capacity(5'd0);
    send_request(KIND_PUT, 32'h0000_0006, $urandom());
    send_request(KIND_PUT, 32'h0000_0007, $urandom());
    send_request(KIND_GET, 32'h0000_0006, $urandom());
    send_request(KIND_GET, 32'h0000_0007, $urandom());

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      quiet = (p % 3 == 2);
      pool_n = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > MAX_ENTRIES) ? MAX_ENTRIES
             : phase_caps[p];
      pool_n += $urandom_range(1, 6);
      key_pool.delete();
      repeat (pool_n) key_pool.push_back($urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) hold_off_req = 1'b1;
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
        else k = $urandom();
        send_request(kind, k, $urandom());
      end
    end
    quiet = 1'b0;

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.due_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("lru_key_value_cache: match");
    end else begin
      $display("lru_key_value_cache: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("lru_key_value_cache: mismatch");
    $finish;
  end

endmodule
